FILE: sv/lphi_pkg.sv
// Shared types, constants and control bundles for the linear-probe hash insert block.
package lphi_pkg;

    localparam int KEY_W          = 31;
    localparam int SLOT_W         = 3;
    localparam int TABLE_SIZE_DEF = 7;

    // The key remainder passes through a short pipeline, tracked by a step counter loaded with REM_STEPS.
    localparam int REM_STEPS  = 3;
    localparam int REM_STEP_W = $clog2(REM_STEPS + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot_select;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              table_full;
        logic [KEY_W-1:0]  slot_value;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic idx_load;
        logic cnt_clear;
        logic rd_probe;
        logic rd_sel;
        logic advance;
        logic wr_key;
        logic clr_wr;
        logic res_ok;
        logic res_full;
        logic res_read;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic rem_done;
        logic slot_empty;
        logic last_probe;
        logic idx_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: sv/lphi_rem.sv
// Multi-cycle unit that reduces a key modulo the table size.
module lphi_rem #(
    parameter int TABLE_SIZE = lphi_pkg::TABLE_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [lphi_pkg::KEY_W-1:0]       key,
    output logic                             done,
    output logic [$clog2(TABLE_SIZE)-1:0]    rem
);
    import lphi_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int REM_W  = IDX_W + 1;
    localparam int PROD_W = 2 * KEY_W;
    // Scaled reciprocal of the table size; the quotient it gives is exact or one low.
    localparam logic [KEY_W-1:0] RECIP     = KEY_W'((64'd1 << KEY_W) / 64'(TABLE_SIZE));
    localparam logic [KEY_W-1:0] DIVISOR_K = KEY_W'(TABLE_SIZE);
    localparam logic [REM_W-1:0] DIVISOR   = REM_W'(TABLE_SIZE);

    logic [KEY_W-1:0]      key_reg, key_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [REM_W-1:0]      rest_reg, rest_next;
    logic [IDX_W-1:0]      rem_reg, rem_next;
    logic [REM_STEP_W-1:0] step_reg, step_next;
    logic [KEY_W-1:0]      quot_est;

    always_comb begin
        key_next  = key_reg;
        step_next = step_reg;
        if (start) begin
            key_next  = key;
            step_next = REM_STEP_W'(REM_STEPS);
        end else if (step_reg != '0) begin
            step_next = step_reg - 1'b1;
        end
    end

    assign prod_next = PROD_W'(key_reg) * PROD_W'(RECIP);

    // With a quotient at most one low, the first remainder lies below twice the table size.
    assign quot_est  = prod_reg[PROD_W-1:KEY_W];
    assign rest_next = REM_W'(key_reg - quot_est * DIVISOR_K);

    always_comb begin
        if (rest_reg >= DIVISOR) begin
            rem_next = IDX_W'(rest_reg - DIVISOR);
        end else begin
            rem_next = rest_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
        key_reg  <= key_next;
        prod_reg <= prod_next;
        rest_reg <= rest_next;
        rem_reg  <= rem_next;
    end

    assign done = (step_reg == '0);
    assign rem  = rem_reg;

endmodule

FILE: sv/lphi_dp.sv
// Datapath: slot memory, probe index and counter, result and output registers.
module lphi_dp #(
    parameter int TABLE_SIZE = lphi_pkg::TABLE_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lphi_pkg::in_item_t  s_payload,
    input  lphi_pkg::dp_cmd_t   cmd,
    output lphi_pkg::dp_sts_t   sts,
    output logic                m_valid,
    input  logic                m_ready,
    output lphi_pkg::out_item_t m_payload
);
    import lphi_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] sel_reg;
    logic              sel_ok_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [KEY_W-1:0]  rdata_reg;
    logic [KEY_W-1:0]  mem [TABLE_SIZE];
    out_item_t         res_reg, res_next;
    out_item_t         out_reg;
    logic              m_valid_reg, m_valid_next;
    logic              rem_done;
    logic [IDX_W-1:0]  rem_value;
    logic [IDX_W-1:0]  sel_addr;

    lphi_rem #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.capture),
        .key     (s_payload.key),
        .done    (rem_done),
        .rem     (rem_value)
    );

    assign sel_addr = IDX_W'(sel_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg    <= s_payload.key;
            sel_reg    <= s_payload.slot_select;
            sel_ok_reg <= (32'(s_payload.slot_select) < 32'(TABLE_SIZE));
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_load) begin
            idx_next = rem_value;
        end else if (cmd.advance || cmd.clr_wr) begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear) begin
            cnt_next = '0;
        end else if (cmd.advance) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // The index register also walks the memory during the clearing pass, so it is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[idx_reg] <= '0;
        end else if (cmd.wr_key) begin
            mem[idx_reg] <= key_reg;
        end
        if (cmd.rd_probe) begin
            rdata_reg <= mem[idx_reg];
        end else if (cmd.rd_sel && sel_ok_reg) begin
            rdata_reg <= mem[sel_addr];
        end
    end

    always_comb begin
        res_next = res_reg;
        if (cmd.res_ok) begin
            res_next.slot       = SLOT_W'(idx_reg);
            res_next.table_full = 1'b0;
            res_next.slot_value = '0;
        end else if (cmd.res_full) begin
            res_next.slot       = '0;
            res_next.table_full = 1'b1;
            res_next.slot_value = '0;
        end else if (cmd.res_read) begin
            res_next.slot       = sel_reg;
            res_next.table_full = 1'b0;
            res_next.slot_value = sel_ok_reg ? rdata_reg : '0;
        end
    end

    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        res_reg <= res_next;
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    assign sts.rem_done   = rem_done;
    assign sts.slot_empty = (rdata_reg == '0);
    assign sts.last_probe = (cnt_reg == LAST_IDX);
    assign sts.idx_last   = (idx_reg == LAST_IDX);
    assign sts.out_free   = ~m_valid_reg | m_ready;

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

FILE: sv/lphi_ctrl.sv
// Controller state machine sequencing clearing, remainder, probing, slot reads and result hand-off.
module lphi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_op,
    output logic              s_ready,
    input  lphi_pkg::dp_sts_t sts,
    output lphi_pkg::dp_cmd_t cmd
);
    import lphi_pkg::*;

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_MOD       = 3'd2;
    localparam logic [2:0] ST_PROBE_RD  = 3'd3;
    localparam logic [2:0] ST_PROBE_CHK = 3'd4;
    localparam logic [2:0] ST_SEL_RD    = 3'd5;
    localparam logic [2:0] ST_SEL_CHK   = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (s_op == OP_READ) ? ST_SEL_RD : ST_MOD;
                end
            end
            ST_MOD: begin
                if (sts.rem_done) begin
                    cmd.idx_load  = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                cmd.rd_probe = 1'b1;
                state_next   = ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
                if (sts.slot_empty) begin
                    cmd.wr_key = 1'b1;
                    cmd.res_ok = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.last_probe) begin
                    // Probe has come round to its start: every slot is taken.
                    cmd.res_full = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_PROBE_RD;
                end
            end
            ST_SEL_RD: begin
                cmd.rd_sel = 1'b1;
                state_next = ST_SEL_CHK;
            end
            ST_SEL_CHK: begin
                cmd.res_read = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/linear_probe_hash_insert.sv
// Reset clears the slot memory in a pass over every slot, with s_ready low throughout.
// An insert takes the key remainder, then probes 1 to TABLE_SIZE slots, each a memory read
// then a check, until one is empty or all are taken. A read reads then checks its slot.
// One item is worked on at a time; the next is accepted the cycle after the previous result
// enters the output register, which may still be waiting on m_ready.
// Top level of the linear-probe hash insert block.
module linear_probe_hash_insert #(
    parameter int TABLE_SIZE = lphi_pkg::TABLE_SIZE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lphi_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output lphi_pkg::out_item_t m_payload
);
    import lphi_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    lphi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_payload.operation),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lphi_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

FILE: tb/linear_probe_hash_insert_tb.sv
// Self-checking testbench for the linear-probe hash insert block, with scoreboard and stimulus.
module linear_probe_hash_insert_tb;
    import lphi_pkg::*;

    localparam int TABLE_SIZE   = TABLE_SIZE_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 262;

    // Keeps its own copy of the slot table and the results still owed by the block.
    class hash_slot_scoreboard;
        logic [KEY_W-1:0] slot_keys [TABLE_SIZE];
        out_item_t        pending_slot_results[$];
        int               mismatches;

        function new();
            foreach (slot_keys[i]) slot_keys[i] = '0;
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // Works out the result of an accepted item and updates the table copy.
        task note_item(in_item_t it);
            out_item_t res;
            int        idx;
            bit        found;
            res   = '0;
            found = 0;
            if (it.operation == OP_INSERT) begin
                idx = int'(it.key % KEY_W'(TABLE_SIZE));
                for (int n = 0; n < TABLE_SIZE; n++) begin
                    if (slot_keys[idx] == '0) begin
                        found = 1;
                        break;
                    end
                    idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
                end
                if (found) begin
                    slot_keys[idx] = it.key;
                    res.slot       = SLOT_W'(idx);
                end else begin
                    res.table_full = 1'b1;
                end
            end else begin
                res.slot = it.slot_select;
                if (int'(it.slot_select) < TABLE_SIZE)
                    res.slot_value = slot_keys[it.slot_select];
            end
            pending_slot_results.push_back(res);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending_slot_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = pending_slot_results.pop_front();
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.table_full !== want.table_full)
                report_mismatch($sformatf("table_full %0b, expected %0b",
                                          got.table_full, want.table_full));
            if (got.slot_value !== want.slot_value)
                report_mismatch($sformatf("slot_value %0h, expected %0h",
                                          got.slot_value, want.slot_value));
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    hash_slot_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    linear_probe_hash_insert #(.TABLE_SIZE(TABLE_SIZE)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_item(s_payload);
            if (m_valid && m_ready)
                sb.check_result(m_payload);
        end
    end

    function automatic in_item_t make_item(logic op, logic [KEY_W-1:0] key,
                                           logic [SLOT_W-1:0] sel);
        in_item_t it;
        it.operation   = op;
        it.key         = key;
        it.slot_select = sel;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t         it;
        logic [KEY_W-1:0] key_bits;
        key_bits = KEY_W'($urandom);
        case ($urandom_range(0, 3))
            0: key_bits = '0;
            1: key_bits = KEY_W'($urandom_range(0, 20));
            default: ;
        endcase
        it.operation   = ($urandom_range(0, 99) < 40) ? OP_READ : OP_INSERT;
        it.key         = key_bits;
        it.slot_select = SLOT_W'($urandom_range(0, 7));
        return it;
    endfunction

    // Valid stays high across back-to-back items; it only drops during a gap.
    task send_item(in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task run_phase(int send_pct, int recv_pct, bit with_hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (with_hold)
            hold_requests++;
        repeat (PHASE_ITEMS) send_item(random_item());
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table, including a select beyond the last slot.
        send_item(make_item(OP_READ, '0, 3'd0));
        send_item(make_item(OP_READ, '0, 3'd6));
        send_item(make_item(OP_READ, {KEY_W{1'b1}}, 3'd7));
        // Key zero lands on the first empty slot but stores nothing.
        send_item(make_item(OP_INSERT, '0, 3'd0));
        send_item(make_item(OP_INSERT, {KEY_W{1'b1}}, 3'd7));
        // Collisions on the last slot wrap round to the start.
        send_item(make_item(OP_INSERT, KEY_W'(6), 3'd0));
        send_item(make_item(OP_INSERT, KEY_W'(13), 3'd0));
        send_item(make_item(OP_INSERT, KEY_W'(20), 3'd5));
        send_item(make_item(OP_INSERT, '0, 3'd0));
        send_item(make_item(OP_READ, '0, 3'd0));
        send_item(make_item(OP_READ, '0, 3'd1));
        send_item(make_item(OP_READ, '0, 3'd2));
        send_item(make_item(OP_READ, '0, 3'd3));
        send_item(make_item(OP_READ, '0, 3'd7));
        // Fill the table, then insert into it once full.
        send_item(make_item(OP_INSERT, KEY_W'(14), 3'd0));
        send_item(make_item(OP_INSERT, KEY_W'(15), 3'd0));
        send_item(make_item(OP_INSERT, KEY_W'(32'h4000_0000), 3'd0));
        send_item(make_item(OP_INSERT, KEY_W'(21), 3'd0));
        send_item(make_item(OP_INSERT, '0, 3'd0));
        send_item(make_item(OP_READ, {KEY_W{1'b1}}, 3'd5));
        send_item(make_item(OP_READ, '0, 3'd6));
        send_item(make_item(OP_READ, {KEY_W{1'b1}}, 3'd7));

        run_phase(0, 0, 1'b1);
        run_phase(81, 0, 1'b0);
        run_phase(0, 81, 1'b0);
        run_phase(13, 13, 1'b1);
        s_valid <= 1'b0;

        while (sb.pending_slot_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending_slot_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: linear_probe_hash_insert.f
sv/lphi_pkg.sv
sv/lphi_rem.sv
sv/lphi_dp.sv
sv/lphi_ctrl.sv
sv/linear_probe_hash_insert.sv
tb/linear_probe_hash_insert_tb.sv
